FILE: design/eulzyx_pkg.sv
`timescale 1ns / 1ps

package eulzyx_pkg;

  // Field formats
  localparam int ANGLE_WIDTH = 16;
  localparam int ELEMENT_WIDTH = 16;
  localparam int ANGLE_FRAC = ANGLE_WIDTH - 3;
  localparam int ELEM_FRAC = ELEMENT_WIDTH - 2;

  // CORDIC depth
  localparam int TRIG_STAGES_DEF = 14;
  localparam int MAX_TRIG_STAGES = 30;

  // Internal fixed point: Q.30 trig values, angle accumulator with room for +-4 rad
  localparam int QBITS = 30;
  localparam int TW = QBITS + 2;
  localparam int ZW = QBITS + 4;
  localparam int PW = 2 * TW;
  localparam int SW = TW + 1;
  localparam int RW = SW + 1;
  localparam int ELEM_SHIFT = QBITS - ELEM_FRAC;

  localparam int NLANES = 3;
  localparam int LANE_ROLL = 0;
  localparam int LANE_PITCH = 1;
  localparam int LANE_YAW = 2;

  localparam logic signed [TW-1:0] GAIN_Q = TW'(652032874);
  localparam logic signed [ZW-1:0] HALF_PI_Q = ZW'(64'sd1686629713);
  localparam logic signed [ZW-1:0] PI_Q = ZW'(64'sd3373259426);
  localparam logic signed [PW-1:0] ROUND_Q = PW'(1) << (QBITS - 1);
  // half an output lsb; zero when the output keeps all 30 fraction bits
  localparam logic signed [RW-1:0] ROUND_E = (RW'(1) << ELEM_SHIFT) >> 1;
  localparam logic signed [ELEMENT_WIDTH-1:0] ELEM_ONE = ELEMENT_WIDTH'(1) << ELEM_FRAC;

  typedef struct packed {
    logic signed [ANGLE_WIDTH-1:0] roll_angle;
    logic signed [ANGLE_WIDTH-1:0] pitch_angle;
    logic signed [ANGLE_WIDTH-1:0] yaw_angle;
  } angles_t;

  typedef struct packed {
    logic signed [ELEMENT_WIDTH-1:0] m00;
    logic signed [ELEMENT_WIDTH-1:0] m01;
    logic signed [ELEMENT_WIDTH-1:0] m02;
    logic signed [ELEMENT_WIDTH-1:0] m10;
    logic signed [ELEMENT_WIDTH-1:0] m11;
    logic signed [ELEMENT_WIDTH-1:0] m12;
    logic signed [ELEMENT_WIDTH-1:0] m20;
    logic signed [ELEMENT_WIDTH-1:0] m21;
    logic signed [ELEMENT_WIDTH-1:0] m22;
  } matrix_t;

  typedef struct packed {
    logic signed [TW-1:0] sin_v;
    logic signed [TW-1:0] cos_v;
  } trig_t;

  // atan(2^-i) in Q.30
  function automatic logic signed [ZW-1:0] atan_q(input int unsigned idx);
    logic signed [ZW-1:0] a;
    case (idx)
      0:       a = ZW'(843314857);
      1:       a = ZW'(497837829);
      2:       a = ZW'(263043837);
      3:       a = ZW'(133525159);
      4:       a = ZW'(67021687);
      5:       a = ZW'(33543516);
      6:       a = ZW'(16775851);
      7:       a = ZW'(8388437);
      8:       a = ZW'(4194283);
      9:       a = ZW'(2097149);
      10:      a = ZW'(1048576);
      11:      a = ZW'(524288);
      12:      a = ZW'(262144);
      13:      a = ZW'(131072);
      14:      a = ZW'(65536);
      15:      a = ZW'(32768);
      16:      a = ZW'(16384);
      17:      a = ZW'(8192);
      18:      a = ZW'(4096);
      19:      a = ZW'(2048);
      20:      a = ZW'(1024);
      21:      a = ZW'(512);
      22:      a = ZW'(256);
      23:      a = ZW'(128);
      24:      a = ZW'(64);
      25:      a = ZW'(32);
      26:      a = ZW'(16);
      27:      a = ZW'(8);
      28:      a = ZW'(4);
      29:      a = ZW'(2);
      default: a = '0;
    endcase
    return a;
  endfunction

  // Q.60 product back to Q.30, half up
  function automatic logic signed [TW-1:0] round_q(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] r;
    r = p + ROUND_Q;
    return r[QBITS+TW-1:QBITS];
  endfunction

  // Q.30 to output format, half up, clamped to +-1
  function automatic logic signed [ELEMENT_WIDTH-1:0] to_element(input logic signed [SW-1:0] v);
    logic signed [RW-1:0] r;
    logic signed [RW-1:0] one;
    one = RW'(ELEM_ONE);
    r = (RW'(v) + ROUND_E) >>> ELEM_SHIFT;
    if (r > one) begin
      r = one;
    end else if (r < -one) begin
      r = -one;
    end
    return r[ELEMENT_WIDTH-1:0];
  endfunction

endpackage

FILE: design/eulzyx_cordic.sv
`timescale 1ns / 1ps

module eulzyx_cordic #(
  parameter int TRIG_STAGES = eulzyx_pkg::TRIG_STAGES_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          in_valid,
  output logic                                          in_stall,
  input  eulzyx_pkg::angles_t                           angles,
  output logic                                          out_valid,
  input  logic                                          out_stall,
  output eulzyx_pkg::trig_t [eulzyx_pkg::NLANES-1:0]    trig
);
  import eulzyx_pkg::*;

  // stage 0: fold, stages 1..TRIG_STAGES: rotations, LAST: sign restore
  localparam int LAST = TRIG_STAGES + 1;
  localparam int ZSH = QBITS - ANGLE_FRAC;

  logic vld [0:LAST];
  logic adv [0:LAST];

  logic signed [TW-1:0] x [0:TRIG_STAGES][NLANES];
  logic signed [TW-1:0] y [0:TRIG_STAGES][NLANES];
  logic signed [ZW-1:0] z [0:TRIG_STAGES][NLANES];
  logic                 neg [0:TRIG_STAGES][NLANES];

  logic signed [ANGLE_WIDTH-1:0] ang [NLANES];
  logic signed [ZW-1:0]          z_in [NLANES];
  logic signed [ZW-1:0]          z_fold [NLANES];
  logic                          neg_fold [NLANES];

  assign ang[LANE_ROLL]  = angles.roll_angle;
  assign ang[LANE_PITCH] = angles.pitch_angle;
  assign ang[LANE_YAW]   = angles.yaw_angle;

  // a stage moves when it is empty or the next one moves
  for (genvar k = 0; k <= LAST; k++) begin : g_ctl
    if (k == LAST) begin : g_end
      assign adv[k] = !vld[k] || !out_stall;
    end else begin : g_mid
      assign adv[k] = !vld[k] || adv[k+1];
    end
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k] <= 1'b0;
        end else if (adv[k]) begin
          vld[k] <= in_valid;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k] <= 1'b0;
        end else if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = vld[LAST];

  // bring the angle into +-pi/2; sine and cosine flip sign for the folded ones
  always_comb begin
    for (int l = 0; l < NLANES; l++) begin
      z_in[l] = ZW'(ang[l]) <<< ZSH;
      if (z_in[l] > HALF_PI_Q) begin
        z_fold[l]   = z_in[l] - PI_Q;
        neg_fold[l] = 1'b1;
      end else if (z_in[l] < -HALF_PI_Q) begin
        z_fold[l]   = z_in[l] + PI_Q;
        neg_fold[l] = 1'b1;
      end else begin
        z_fold[l]   = z_in[l];
        neg_fold[l] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      for (int l = 0; l < NLANES; l++) begin
        x[0][l]   <= GAIN_Q;
        y[0][l]   <= '0;
        z[0][l]   <= z_fold[l];
        neg[0][l] <= neg_fold[l];
      end
    end
  end

  for (genvar i = 0; i < TRIG_STAGES; i++) begin : g_rot
    localparam logic signed [ZW-1:0] ATAN_I = atan_q(i);
    always_ff @(posedge clk) begin
      if (adv[i+1]) begin
        for (int l = 0; l < NLANES; l++) begin
          if (!z[i][l][ZW-1]) begin
            x[i+1][l] <= x[i][l] - (y[i][l] >>> i);
            y[i+1][l] <= y[i][l] + (x[i][l] >>> i);
            z[i+1][l] <= z[i][l] - ATAN_I;
          end else begin
            x[i+1][l] <= x[i][l] + (y[i][l] >>> i);
            y[i+1][l] <= y[i][l] - (x[i][l] >>> i);
            z[i+1][l] <= z[i][l] + ATAN_I;
          end
          neg[i+1][l] <= neg[i][l];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[LAST]) begin
      for (int l = 0; l < NLANES; l++) begin
        trig[l].sin_v <= neg[TRIG_STAGES][l] ? -y[TRIG_STAGES][l] : y[TRIG_STAGES][l];
        trig[l].cos_v <= neg[TRIG_STAGES][l] ? -x[TRIG_STAGES][l] : x[TRIG_STAGES][l];
      end
    end
  end

endmodule

FILE: design/eulzyx_matmul.sv
`timescale 1ns / 1ps

module eulzyx_matmul (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       in_valid,
  output logic                                       in_stall,
  input  eulzyx_pkg::trig_t [eulzyx_pkg::NLANES-1:0] trig,
  output logic                                       out_valid,
  input  logic                                       out_stall,
  output eulzyx_pkg::matrix_t                        matrix
);
  import eulzyx_pkg::*;

  // 1: first products, 2: round, 3: triple products, 4: round, 5: sums, 6: output
  localparam int NST = 6;

  logic vld [NST];
  logic adv [NST];

  logic signed [TW-1:0] sr, cr, sp, cp, sy, cy;

  logic signed [PW-1:0] p1_cysp, p1_sysp, p1_cycp, p1_sycp, p1_cpsr, p1_cpcr;
  logic signed [PW-1:0] p1_sycr, p1_sysr, p1_cycr, p1_cysr;
  logic signed [TW-1:0] p1_sp, p1_sr, p1_cr;

  logic signed [TW-1:0] r2_cysp, r2_sysp, r2_cycp, r2_sycp, r2_cpsr, r2_cpcr;
  logic signed [TW-1:0] r2_sycr, r2_sysr, r2_cycr, r2_cysr, r2_sr, r2_cr;
  logic signed [ELEMENT_WIDTH-1:0] r2_m20;

  logic signed [PW-1:0] p3_01, p3_02, p3_11, p3_12;
  logic signed [TW-1:0] p3_cycp, p3_sycp, p3_cpsr, p3_cpcr;
  logic signed [TW-1:0] p3_sycr, p3_sysr, p3_cycr, p3_cysr;
  logic signed [ELEMENT_WIDTH-1:0] p3_m20;

  logic signed [TW-1:0] r4_01, r4_02, r4_11, r4_12;
  logic signed [TW-1:0] r4_cycp, r4_sycp, r4_cpsr, r4_cpcr;
  logic signed [TW-1:0] r4_sycr, r4_sysr, r4_cycr, r4_cysr;
  logic signed [ELEMENT_WIDTH-1:0] r4_m20;

  logic signed [SW-1:0] s5_00, s5_01, s5_02, s5_10, s5_11, s5_12, s5_21, s5_22;
  logic signed [ELEMENT_WIDTH-1:0] s5_m20;

  assign sr = trig[LANE_ROLL].sin_v;
  assign cr = trig[LANE_ROLL].cos_v;
  assign sp = trig[LANE_PITCH].sin_v;
  assign cp = trig[LANE_PITCH].cos_v;
  assign sy = trig[LANE_YAW].sin_v;
  assign cy = trig[LANE_YAW].cos_v;

  for (genvar k = 0; k < NST; k++) begin : g_ctl
    if (k == NST - 1) begin : g_end
      assign adv[k] = !vld[k] || !out_stall;
    end else begin : g_mid
      assign adv[k] = !vld[k] || adv[k+1];
    end
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k] <= 1'b0;
        end else if (adv[k]) begin
          vld[k] <= in_valid;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k] <= 1'b0;
        end else if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      p1_cysp <= cy * sp;
      p1_sysp <= sy * sp;
      p1_cycp <= cy * cp;
      p1_sycp <= sy * cp;
      p1_cpsr <= cp * sr;
      p1_cpcr <= cp * cr;
      p1_sycr <= sy * cr;
      p1_sysr <= sy * sr;
      p1_cycr <= cy * cr;
      p1_cysr <= cy * sr;
      p1_sp   <= sp;
      p1_sr   <= sr;
      p1_cr   <= cr;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      r2_cysp <= round_q(p1_cysp);
      r2_sysp <= round_q(p1_sysp);
      r2_cycp <= round_q(p1_cycp);
      r2_sycp <= round_q(p1_sycp);
      r2_cpsr <= round_q(p1_cpsr);
      r2_cpcr <= round_q(p1_cpcr);
      r2_sycr <= round_q(p1_sycr);
      r2_sysr <= round_q(p1_sysr);
      r2_cycr <= round_q(p1_cycr);
      r2_cysr <= round_q(p1_cysr);
      r2_sr   <= p1_sr;
      r2_cr   <= p1_cr;
      r2_m20  <= to_element(-SW'(p1_sp));
    end
  end

  // second factor pass: (cy*sp) and (sy*sp) times roll terms
  always_ff @(posedge clk) begin
    if (adv[2]) begin
      p3_01   <= r2_cysp * r2_sr;
      p3_02   <= r2_cysp * r2_cr;
      p3_11   <= r2_sysp * r2_sr;
      p3_12   <= r2_sysp * r2_cr;
      p3_cycp <= r2_cycp;
      p3_sycp <= r2_sycp;
      p3_cpsr <= r2_cpsr;
      p3_cpcr <= r2_cpcr;
      p3_sycr <= r2_sycr;
      p3_sysr <= r2_sysr;
      p3_cycr <= r2_cycr;
      p3_cysr <= r2_cysr;
      p3_m20  <= r2_m20;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      r4_01   <= round_q(p3_01);
      r4_02   <= round_q(p3_02);
      r4_11   <= round_q(p3_11);
      r4_12   <= round_q(p3_12);
      r4_cycp <= p3_cycp;
      r4_sycp <= p3_sycp;
      r4_cpsr <= p3_cpsr;
      r4_cpcr <= p3_cpcr;
      r4_sycr <= p3_sycr;
      r4_sysr <= p3_sysr;
      r4_cycr <= p3_cycr;
      r4_cysr <= p3_cysr;
      r4_m20  <= p3_m20;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s5_00  <= SW'(r4_cycp);
      s5_01  <= SW'(r4_01) - SW'(r4_sycr);
      s5_02  <= SW'(r4_02) + SW'(r4_sysr);
      s5_10  <= SW'(r4_sycp);
      s5_11  <= SW'(r4_11) + SW'(r4_cycr);
      s5_12  <= SW'(r4_12) - SW'(r4_cysr);
      s5_21  <= SW'(r4_cpsr);
      s5_22  <= SW'(r4_cpcr);
      s5_m20 <= r4_m20;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      matrix.m00 <= to_element(s5_00);
      matrix.m01 <= to_element(s5_01);
      matrix.m02 <= to_element(s5_02);
      matrix.m10 <= to_element(s5_10);
      matrix.m11 <= to_element(s5_11);
      matrix.m12 <= to_element(s5_12);
      matrix.m20 <= s5_m20;
      matrix.m21 <= to_element(s5_21);
      matrix.m22 <= to_element(s5_22);
    end
  end

endmodule

FILE: design/euler_zyx_rotation_matrix_top.sv
// Depth: TRIG_STAGES + 8 register stages between an input beat and its output beat.
// Throughput: one angle triple per cycle while matrix_stall is low, set by the fully
// pipelined CORDIC and multipliers.
// Each stage fills whenever it is empty, so input is held off only when all stages are full.
// Reset (rst, synchronous) clears the stage valid bits; data registers are not reset.
`timescale 1ns / 1ps

module euler_zyx_rotation_matrix_top #(
  parameter int TRIG_STAGES = eulzyx_pkg::TRIG_STAGES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                angle_valid,
  output logic                angle_stall,
  input  eulzyx_pkg::angles_t angles,
  output logic                matrix_valid,
  input  logic                matrix_stall,
  output eulzyx_pkg::matrix_t matrix
);
  import eulzyx_pkg::*;

  logic                 trig_valid;
  logic                 trig_stall;
  trig_t [NLANES-1:0]   trig;

  eulzyx_cordic #(
    .TRIG_STAGES (TRIG_STAGES)
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (angle_valid),
    .in_stall  (angle_stall),
    .angles    (angles),
    .out_valid (trig_valid),
    .out_stall (trig_stall),
    .trig      (trig)
  );

  eulzyx_matmul u_matmul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (trig_valid),
    .in_stall  (trig_stall),
    .trig      (trig),
    .out_valid (matrix_valid),
    .out_stall (matrix_stall),
    .matrix    (matrix)
  );

endmodule

FILE: design/eulzyx_checker.sv
`timescale 1ns / 1ps

module eulzyx_checker (
  input logic                clk,
  input logic                rst,
  input logic                angle_valid,
  input logic                angle_stall,
  input eulzyx_pkg::angles_t angles,
  input logic                matrix_valid,
  input logic                matrix_stall,
  input eulzyx_pkg::matrix_t matrix
);
  import eulzyx_pkg::*;

  localparam int NELEM = 9;

  logic [NELEM*ELEMENT_WIDTH-1:0] mbits;
  logic                           in_range;

  assign mbits = matrix;

  always_comb begin
    in_range = 1'b1;
    for (int k = 0; k < NELEM; k++) begin
      if ($signed(mbits[k*ELEMENT_WIDTH +: ELEMENT_WIDTH]) > ELEM_ONE ||
          $signed(mbits[k*ELEMENT_WIDTH +: ELEMENT_WIDTH]) < -ELEM_ONE) begin
        in_range = 1'b0;
      end
    end
  end

  // input is held off only when every stage is full and the output beat is blocked
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    angle_stall |-> (matrix_valid && matrix_stall))
    else $error("input stalled while pipeline has room");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !matrix_valid)
    else $error("output valid right after reset");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (angle_valid && angle_stall) |=> (angle_valid && $stable(angles)))
    else $error("stalled input beat changed or dropped");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (matrix_valid && matrix_stall) |=> (matrix_valid && $stable(matrix)))
    else $error("stalled output beat changed or dropped");

  a_elem_range: assert property (@(posedge clk) disable iff (rst)
    matrix_valid |-> in_range)
    else $error("matrix element beyond +-1");

endmodule

bind euler_zyx_rotation_matrix_top eulzyx_checker u_eulzyx_checker (
  .clk          (clk),
  .rst          (rst),
  .angle_valid  (angle_valid),
  .angle_stall  (angle_stall),
  .angles       (angles),
  .matrix_valid (matrix_valid),
  .matrix_stall (matrix_stall),
  .matrix       (matrix)
);
